/* src/gdf_pkg.sv */
// Shared constants, types and twiddle/rounding functions for the group delay block.
package gdf_pkg;

  localparam int MAX_FFT_SIZE = 64;
  localparam int ADDR_W = $clog2(MAX_FFT_SIZE);
  localparam int COEF_W = 16;
  localparam int XW = 23;
  localparam int UW = 29;
  localparam int ACC_W = 48;

  localparam logic CFG_FFT_LOG2 = 1'b0;
  localparam logic CFG_ARMA = 1'b1;

  localparam logic [2:0] LOG2_MIN = 3'd3;
  localparam logic [2:0] LOG2_MAX = 3'd6;

  localparam logic [15:0] QUARTER_COS [17] = '{
    16'd16384, 16'd16305, 16'd16069, 16'd15678, 16'd15137, 16'd14449, 16'd13623,
    16'd12665, 16'd11585, 16'd10394, 16'd9102, 16'd7723, 16'd6270, 16'd4756,
    16'd3196, 16'd1606, 16'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] xi;
    logic signed [UW-1:0] ur;
    logic signed [UW-1:0] ui;
  } spectrum_t;

  typedef struct packed {
    logic signed [15:0] delay;
    logic               zero;
  } result_t;

  // Q1.14 cosine of 2*pi*m/64 built from the quarter-wave table.
  function automatic logic signed [15:0] twiddle_cos(input logic [5:0] m);
    logic [6:0] mm;
    logic [15:0] q;
    mm = {1'b0, m};
    if (mm <= 7'd16) begin
      q = QUARTER_COS[mm[4:0]];
      return $signed(q);
    end else if (mm <= 7'd32) begin
      q = QUARTER_COS[5'(7'd32 - mm)];
      return -$signed(q);
    end else if (mm <= 7'd48) begin
      q = QUARTER_COS[5'(mm - 7'd32)];
      return -$signed(q);
    end else begin
      q = QUARTER_COS[5'(7'd64 - mm)];
      return $signed(q);
    end
  endfunction

  function automatic logic signed [15:0] twiddle_sin(input logic [5:0] m);
    return twiddle_cos(m + 6'd48);
  endfunction

  // Drop 14 fraction bits, rounding half away from zero.
  function automatic logic signed [ACC_W-1:0] round_q14(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    mag = (mag + ACC_W'(8192)) >> 14;
    return v[ACC_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

/* src/gdf_coef_ram.sv */
// Coefficient memory: one write port, one registered read port.
module gdf_coef_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [gdf_pkg::ADDR_W-1:0]   waddr,
  input  logic signed [15:0]           wdata,
  input  logic [gdf_pkg::ADDR_W-1:0]   raddr,
  output logic signed [15:0]           rdata
);
  import gdf_pkg::*;

  logic signed [15:0] mem [MAX_FFT_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gdf_dft.sv */
// One bin of both spectra: streams the coefficient memory through a multiply-accumulate pipe.
module gdf_dft (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [5:0]                   bin,
  input  logic [2:0]                   log2n,
  input  logic                         arma,
  output logic [gdf_pkg::ADDR_W-1:0]   rd_addr,
  input  logic signed [15:0]           rd_data,
  output logic                         done,
  output gdf_pkg::spectrum_t           spec
);
  import gdf_pkg::*;

  logic busy, issuing;
  logic [5:0] n, m, dm, n1, m1, n2;
  logic p1, p2, p3, p4;
  logic signed [16:0] v2, v3;
  logic signed [23:0] vn3;
  logic signed [15:0] cos2, sin2, cos3, sin3;
  logic signed [32:0] pxc, pxs;
  logic signed [39:0] puc, pus;
  logic signed [ACC_W-1:0] axr, axi, aur, aui;
  logic signed [ACC_W-1:0] rxr, rxi, rur, rui;
  logic [6:0] nsize;

  assign rd_addr = n;
  assign nsize = 7'd1 << log2n;

  always_comb begin
    rxr = round_q14(axr);
    rxi = round_q14(axi);
    rur = round_q14(aur);
    rui = round_q14(aui);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      issuing <= 1'b0;
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
      p4 <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      p1 <= issuing;
      p2 <= p1;
      p3 <= p2;
      p4 <= p3;
      if (start) begin
        busy <= 1'b1;
        issuing <= 1'b1;
      end else if (issuing) begin
        if (n == 6'(nsize - 7'd1)) begin
          issuing <= 1'b0;
        end
      end else if (busy && !p1 && !p2 && !p3 && !p4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= '0;
      m <= '0;
      dm <= 6'(bin << (3'd6 - log2n));
      axr <= '0;
      axi <= '0;
      aur <= '0;
      aui <= '0;
    end else begin
      if (issuing) begin
        n <= n + 6'd1;
        m <= m + dm;
      end
      if (p4) begin
        axr <= axr + ACC_W'(pxc);
        axi <= axi - ACC_W'(pxs);
        aur <= aur + ACC_W'(puc);
        aui <= aui - ACC_W'(pus);
      end
    end
    n1 <= n;
    m1 <= m;
    // The first coefficient reads as exactly one in ARMA mode.
    v2 <= (n1 == 6'd0 && arma) ? 17'sd32768 : 17'(rd_data);
    n2 <= n1;
    cos2 <= twiddle_cos(m1);
    sin2 <= twiddle_sin(m1);
    v3 <= v2;
    vn3 <= v2 * $signed({1'b0, n2});
    cos3 <= cos2;
    sin3 <= sin2;
    pxc <= v3 * cos3;
    pxs <= v3 * sin3;
    puc <= vn3 * cos3;
    pus <= vn3 * sin3;
    if (busy && !issuing && !p1 && !p2 && !p3 && !p4) begin
      spec.xr <= XW'(rxr);
      spec.xi <= XW'(rxi);
      spec.ur <= UW'(rur);
      spec.ui <= UW'(rui);
    end
  end

endmodule

/* src/gdf_div.sv */
// Group delay of one bin: cross products, then a restoring divider one quotient bit a cycle.
module gdf_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gdf_pkg::spectrum_t  spec,
  input  logic                arma,
  output logic                done,
  output gdf_pkg::result_t    res
);
  import gdf_pkg::*;

  typedef enum logic [6:0] {
    D_IDLE = 7'b0000001,
    D_M1   = 7'b0000010,
    D_M2   = 7'b0000100,
    D_SUM  = 7'b0001000,
    D_PREP = 7'b0010000,
    D_ITER = 7'b0100000,
    D_FIN  = 7'b1000000
  } dstate_t;

  dstate_t state;
  logic signed [51:0] prod1, prod2;
  logic [45:0] sq1, sq2;
  logic signed [52:0] num;
  logic [46:0] den;
  logic [63:0] rem, dsh, dividend, den_lim;
  logic [52:0] mag;
  logic [15:0] qm;
  logic [3:0] cnt;
  logic neg;
  logic signed [16:0] qs;

  assign mag = num[52] ? 53'(-num) : 53'(num);
  assign dividend = ({11'd0, mag} << 8) + 64'(den >> 1);
  assign den_lim = 64'(den) << 15;
  assign qs = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: if (start) state <= D_M1;
        D_M1:   state <= D_M2;
        D_M2:   state <= D_SUM;
        D_SUM:  state <= D_PREP;
        D_PREP: begin
          if (den == '0 || dividend >= den_lim) begin
            state <= D_FIN;
          end else begin
            state <= D_ITER;
          end
        end
        D_ITER: if (cnt == 4'd0) state <= D_FIN;
        D_FIN: begin
          state <= D_IDLE;
          done <= 1'b1;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_M1: begin
        prod1 <= spec.xr * spec.ur;
        sq1 <= 46'(spec.xr) * 46'(spec.xr);
      end
      D_M2: begin
        prod2 <= spec.xi * spec.ui;
        sq2 <= 46'(spec.xi) * 46'(spec.xi);
      end
      D_SUM: begin
        num <= 53'(prod1) + 53'(prod2);
        den <= 47'(sq1) + 47'(sq2);
      end
      D_PREP: begin
        neg <= num[52] ^ arma;
        rem <= dividend;
        dsh <= 64'(den) << 14;
        cnt <= 4'd14;
        qm <= (dividend >= den_lim) ? 16'd32768 : 16'd0;
      end
      D_ITER: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          qm[cnt] <= 1'b1;
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
      end
      D_FIN: begin
        res.zero <= (den == '0);
        if (den == '0) begin
          res.delay <= '0;
        end else if (!neg && qm[15]) begin
          res.delay <= 16'sd32767;
        end else begin
          res.delay <= 16'(qs);
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/filter_group_delay_fft_core.sv */
// Group delay of a filter frame: top level with loading, bin sequencing and output register.
// The frame's last coefficient starts the work; the N/2+1 bins are then worked through one at a
// time, each with one pass over the coefficient memory and then the bit-serial divider.
// Loading takes one coefficient per cycle; no new coefficient is taken until the last bin's
// result has been loaded into the output register.
// Reset (rst, synchronous, active high) clears the sample count, out_valid and
// the sequencers and sets fft_log2_size to 6 and arma_mode to 0; memories are not cleared.
module filter_group_delay_fft_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coefficient,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         bin_index,
  output logic signed [15:0] delay_value,
  output logic               zero_magnitude,
  output logic               last_bin
);
  import gdf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DFT  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [2:0] fft_log2_size, lg;
  logic arma_mode;
  logic [6:0] sample_count, count_inc, nsize;
  logic [5:0] half, k;
  logic accept, ram_we, dft_start, dft_done, div_start, div_done;
  logic [ADDR_W-1:0] rd_addr;
  logic signed [15:0] rd_data;
  spectrum_t spec;
  result_t res;

  assign lg = (fft_log2_size < LOG2_MIN) ? LOG2_MIN :
              (fft_log2_size > LOG2_MAX) ? LOG2_MAX : fft_log2_size;
  assign nsize = 7'd1 << lg;
  assign half = 6'(nsize >> 1);
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign count_inc = sample_count + 7'd1;
  assign ram_we = accept && !sample_count[6];

  gdf_coef_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(sample_count[5:0]), .wdata(coefficient),
    .raddr(rd_addr), .rdata(rd_data)
  );

  gdf_dft u_dft (
    .clk(clk), .rst(rst), .start(dft_start), .bin(k), .log2n(lg), .arma(arma_mode),
    .rd_addr(rd_addr), .rd_data(rd_data), .done(dft_done), .spec(spec)
  );

  gdf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .spec(spec), .arma(arma_mode),
    .done(div_done), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fft_log2_size <= 3'd6;
      arma_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FFT_LOG2: fft_log2_size <= cfg_data;
        CFG_ARMA:     arma_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sample_count <= '0;
      k <= '0;
      dft_start <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dft_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count_inc >= nsize) begin
              sample_count <= '0;
              k <= '0;
              dft_start <= 1'b1;
              state <= ST_DFT;
            end else begin
              sample_count <= count_inc;
            end
          end
        end
        ST_DFT: begin
          if (dft_done) begin
            div_start <= 1'b1;
            state <= ST_DIV;
          end
        end
        ST_DIV: if (div_done) state <= ST_OUT;
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (k == half) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 6'd1;
              dft_start <= 1'b1;
              state <= ST_DFT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload is loaded together with out_valid in the output state.
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      bin_index <= k;
      delay_value <= res.delay;
      zero_magnitude <= res.zero;
      last_bin <= (k == half);
    end
  end

endmodule

/* src/gdf_checker.sv */
// Port-level checks on the result channel of the group delay block.
module gdf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [5:0]         bin_index,
  input logic signed [15:0] delay_value,
  input logic               zero_magnitude,
  input logic               last_bin
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(delay_value) && $stable(bin_index))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_magnitude |-> delay_value == 16'sd0)
    else $error("zero magnitude with nonzero delay");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_bin |-> bin_index == 6'd4 || bin_index == 6'd8 ||
                              bin_index == 6'd16 || bin_index == 6'd32)
    else $error("last bin is not half the frame size");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind filter_group_delay_fft_core gdf_checker u_gdf_checker (.*);

/* tb/filter_group_delay_fft_core_tb.sv */
// Self-checking testbench for the FFT-based group delay block.
`timescale 1ns / 1ps

module filter_group_delay_fft_core_tb;
  import gdf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [5:0]         bin;
    logic signed [15:0] delay;
    logic               zero;
    logic               last;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_FFT_LOG2;
  logic [2:0] cfg_data = 3'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] coefficient = 16'sd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] bin_index;
  logic signed [15:0] delay_value;
  logic zero_magnitude;
  logic last_bin;

  filter_group_delay_fft_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
    .out_valid(out_valid), .out_stall(out_stall), .bin_index(bin_index),
    .delay_value(delay_value), .zero_magnitude(zero_magnitude), .last_bin(last_bin)
  );

  always #6 clk = ~clk;

  // Local copy of the block state.
  logic [2:0] size_reg = 3'd6;
  logic arma_reg = 1'b0;
  int coef_mem [MAX_FFT_SIZE];
  int loaded = 0;

  logic signed [15:0] coef_q [$];
  bin_result_t delay_q [$];
  int errors = 0;
  int cyc = 0;
  bit coef_sent = 1'b0;
  bit hold_armed = 1'b0;
  int hold_left = 0;

  function automatic longint cos_q14(int m);
    int mm;
    mm = m & 63;
    if (mm <= 16) return longint'(QUARTER_COS[mm]);
    if (mm <= 32) return -longint'(QUARTER_COS[32 - mm]);
    if (mm <= 48) return -longint'(QUARTER_COS[mm - 32]);
    return longint'(QUARTER_COS[64 - mm]);
  endfunction

  function automatic longint drop_q14(longint v);
    if (v >= 0) return (v + 8192) >>> 14;
    return -((-v + 8192) >>> 14);
  endfunction

  // Take one coefficient; on a full frame queue the group delay of bins 0 to N/2.
  function automatic void take_coefficient(logic signed [15:0] c);
    int lg, n_pts, stride, half, m;
    longint xr, xi, ur, ui, v, num, den, q;
    longint unsigned mag, qm;
    bin_result_t r;
    lg = size_reg;
    if (lg < 3) lg = 3;
    if (lg > 6) lg = 6;
    n_pts = 1 << lg;
    stride = 64 >> lg;
    half = n_pts / 2;
    if (loaded < MAX_FFT_SIZE) coef_mem[loaded] = c;
    loaded = (loaded + 1) & 127;
    if (loaded < n_pts) return;
    loaded = 0;
    for (int k = 0; k <= half; k++) begin
      xr = 0; xi = 0; ur = 0; ui = 0;
      for (int n = 0; n < n_pts; n++) begin
        v = (n == 0 && arma_reg) ? 64'sd32768 : longint'(coef_mem[n]);
        m = (n * k * stride) & 63;
        xr += v * cos_q14(m);
        xi -= v * cos_q14(m + 48);
        ur += v * n * cos_q14(m);
        ui -= v * n * cos_q14(m + 48);
      end
      xr = drop_q14(xr); xi = drop_q14(xi);
      ur = drop_q14(ur); ui = drop_q14(ui);
      num = xr * ur + xi * ui;
      den = xr * xr + xi * xi;
      q = 0;
      r.zero = (den == 0);
      if (den != 0) begin
        mag = (num < 0) ? longint'(-num) : longint'(num);
        qm = (mag * 256 + longint'(den) / 2) / longint'(den);
        q = (num < 0) ? -longint'(qm) : longint'(qm);
        if (arma_reg) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
      r.bin = k[5:0];
      r.delay = q[15:0];
      r.last = (k == half);
      delay_q.push_back(r);
    end
  endfunction

  // Gaps are suppressed in one window so that a stretch runs at full rate.
  function automatic bit take_gap();
    if (cyc > 9000 && cyc < 16000) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("filter_group_delay_fft_core test failed");
      $finish;
    end
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    bin_result_t e;
    coef_sent = in_valid && !in_stall && !rst;
    if (coef_sent) take_coefficient(coefficient);
    if (!rst && out_valid && !out_stall) begin
      if (delay_q.size() == 0) begin
        $display("%0t: unexpected result bin %0d delay %0d", $time, bin_index, delay_value);
        errors++;
      end else begin
        e = delay_q.pop_front();
        if (bin_index !== e.bin || delay_value !== e.delay ||
            zero_magnitude !== e.zero || last_bin !== e.last) begin
          $display("%0t: expected bin %0d delay %0d zero %0b last %0b, got %0d %0d %0b %0b",
                   $time, e.bin, e.delay, e.zero, e.last,
                   bin_index, delay_value, zero_magnitude, last_bin);
          errors++;
        end
      end
    end
  end

  // Coefficient driver: a new transfer is offered once the previous one is taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || coef_sent)) begin
      if (coef_q.size() > 0 && !take_gap()) begin
        in_valid <= 1'b1;
        coefficient <= coef_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off while the sender keeps going.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_armed && out_valid) begin
      hold_armed <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= take_gap();
    end
  end

  task automatic write_reg(logic idx, logic [2:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_FFT_LOG2) size_reg = val;
    else arma_reg = val[0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (coef_q.size() == 0 && !in_valid && delay_q.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_frame(int n_pts);
    for (int i = 0; i < n_pts; i++) coef_q.push_back(rand_coef());
  endtask

  initial begin
    logic signed [15:0] corner [8];
    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001,
               16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh4000};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: corner values, an all-zero frame, and the corner values in ARMA mode.
    write_reg(CFG_FFT_LOG2, 3'd3);
    foreach (corner[i]) coef_q.push_back(corner[i]);
    wait_idle();
    for (int i = 0; i < 8; i++) coef_q.push_back(16'sh0000);
    wait_idle();
    write_reg(CFG_ARMA, 1'b1);
    foreach (corner[i]) coef_q.push_back(corner[i]);
    wait_idle();

    // Size below range acts as eight points; back-to-back frames under a long hold-off.
    write_reg(CFG_ARMA, 1'b0);
    write_reg(CFG_FFT_LOG2, 3'd0);
    hold_armed = 1'b1;
    repeat (2) queue_frame(8);
    wait_idle();

    // Shrinking the size mid-frame completes the frame on the next transfer.
    write_reg(CFG_FFT_LOG2, 3'd5);
    queue_frame(10);
    wait_idle();
    write_reg(CFG_FFT_LOG2, 3'd3);
    queue_frame(1);
    wait_idle();

    // Size above range acts as 64 points.
    write_reg(CFG_FFT_LOG2, 3'd7);
    write_reg(CFG_ARMA, 1'($urandom_range(1)));
    queue_frame(64);
    wait_idle();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("filter_group_delay_fft_core test passed");
    end else begin
      $display("filter_group_delay_fft_core test failed");
    end
    $finish;
  end

endmodule
